// ----- rtl/core/iopr_pkg.sv -----
// Shared types, constants and decode helpers for the I/O page register decoder.
// No dependencies; the other files in rtl/core, the channel interface apart, refer to this package by scoped names.
`timescale 1ns / 1ps

package iopr_pkg;

  // Access commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Field widths of one bus access
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned BANK_W = 4;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned ROW_W  = 5;

  // Register file geometry
  localparam int unsigned VIDEO_DEPTH  = 64;
  localparam int unsigned SOUND_DEPTH  = 32;
  localparam int unsigned TIMER_DEPTH  = 16;
  localparam int unsigned COLOUR_DEPTH = 1024;
  localparam int unsigned VIDEO_AW     = $clog2(VIDEO_DEPTH);
  localparam int unsigned SOUND_AW     = $clog2(SOUND_DEPTH);
  localparam int unsigned TIMER_AW     = $clog2(TIMER_DEPTH);
  localparam int unsigned COLOUR_AW    = $clog2(COLOUR_DEPTH);

  // Video registers with side effects
  localparam logic [VIDEO_AW-1:0] VID_CTRL_V     = 6'h11;
  localparam logic [VIDEO_AW-1:0] VID_CTRL_H     = 6'h16;
  localparam logic [VIDEO_AW-1:0] VID_MEM_PTR    = 6'h18;
  localparam logic [VIDEO_AW-1:0] VID_BORDER     = 6'h20;
  localparam logic [VIDEO_AW-1:0] VID_BACKGROUND = 6'h21;

  // Timer chip registers
  localparam logic [TIMER_AW-1:0] TMR_PORT_A = 4'h0;
  localparam logic [TIMER_AW-1:0] TMR_DDR_A  = 4'h2;

  // Bank regions of the page
  typedef enum logic [2:0] {
    REGION_VIDEO,
    REGION_SOUND,
    REGION_COLOUR,
    REGION_TIMER_ONE,
    REGION_TIMER_TWO,
    REGION_UNMAPPED
  } region_e;

  // One bus access
  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  // One access result
  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic                 frame_changed;
    logic                 repaint_all;
    logic                 palette_update;
    logic                 border_changed;
    logic                 colour_changed;
    logic [COLOUR_AW-1:0] colour_index;
    logic [ROW_W-1:0]     colour_row;
  } rsp_t;

  // Register file read byte and change flags
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              frame_changed;
    logic              repaint_all;
    logic              palette_update;
    logic              border_changed;
  } rf_status_t;

  // Colour store write port
  typedef struct packed {
    logic                 en;
    logic [COLOUR_AW-1:0] index;
    logic [NIB_W-1:0]     nib;
  } colour_wr_t;

  function automatic region_e bank_region(input logic [BANK_W-1:0] bank);
    region_e region;
    if (bank inside {[4'd0:4'd3]}) begin
      region = REGION_VIDEO;
    end else if (bank inside {[4'd4:4'd7]}) begin
      region = REGION_SOUND;
    end else if (bank inside {[4'd8:4'd11]}) begin
      region = REGION_COLOUR;
    end else if (bank == 4'd12) begin
      region = REGION_TIMER_ONE;
    end else if (bank == 4'd13) begin
      region = REGION_TIMER_TWO;
    end else begin
      region = REGION_UNMAPPED;
    end
    return region;
  endfunction

  function automatic logic [DATA_W-1:0] video_reset_value(input logic [VIDEO_AW-1:0] r);
    logic [DATA_W-1:0] v;
    case (r)
      VID_CTRL_V:     v = 8'h1B;
      VID_CTRL_H:     v = 8'hC8;
      VID_MEM_PTR:    v = 8'h15;
      VID_BORDER:     v = 8'h0E;
      VID_BACKGROUND: v = 8'h06;
      default:        v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] timer_one_reset_value(input logic [TIMER_AW-1:0] r);
    return (r == TMR_DDR_A) ? 8'hFF : 8'h00;
  endfunction

  function automatic logic [DATA_W-1:0] timer_two_reset_value(input logic [TIMER_AW-1:0] r);
    logic [DATA_W-1:0] v;
    case (r)
      TMR_PORT_A: v = 8'h17;
      TMR_DDR_A:  v = 8'h3F;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/iopr_chan_if.sv -----
// Valid/ready channel carrying one payload of a type chosen per instance.
// Depends on nothing; payload types come from iopr_pkg at the instance.
`timescale 1ns / 1ps

interface iopr_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/io_page_register_file_decode_core.sv -----
// Top level of the I/O page register decoder: request stage, result register, files.
// Depends on iopr_pkg, iopr_chan_if, iopr_reg_file and iopr_colour_store.
//
//   Channel  Dir  Payload           Accepted when
//   req_i    in   iopr_pkg::req_t   req_i.valid && req_i.ready
//   rsp_o    out  iopr_pkg::rsp_t   rsp_o.valid && rsp_o.ready
//
// One request per cycle while neither the response side nor a power-on load stalls it; each
// request yields one response through the request stage, then the result register.
// The colour store and the video file each take one registered read on acceptance and
// one write as the request leaves the request stage, forwarded to a following read.
// After reset the colour store is swept to zero while the video file loads its
// power-on values; req_i.ready stays low until both finish.
// A stalled response holds the request stage; a new request enters as the stage moves on.
`timescale 1ns / 1ps

module io_page_register_file_decode_core #(
  parameter int unsigned SCREEN_COLUMNS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  iopr_chan_if.sink          req_i,
  iopr_chan_if.source        rsp_o
);

  logic                 s1_valid_q;
  iopr_pkg::req_t       s1_req_q;
  logic                 out_valid_q;
  iopr_pkg::rsp_t       out_q;
  iopr_pkg::rsp_t       out_d;

  logic                 in_ready;
  logic                 accept;
  logic                 s1_adv;
  logic                 busy;
  logic                 rf_busy;
  logic                 colour_busy;
  iopr_pkg::region_e    region;
  logic                 is_write;
  logic                 is_colour;
  logic                 colour_chg;
  logic [iopr_pkg::NIB_W-1:0] old_nib;
  logic [iopr_pkg::ROW_W-1:0] row;
  iopr_pkg::colour_wr_t colour_wr;
  iopr_pkg::rf_status_t rf_status;
  iopr_pkg::req_t       req_data;

  assign req_data = req_i.data;
  assign busy     = rf_busy | colour_busy;

  // Handshake: the request stage moves when the result register is free or draining
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready    = !busy && (!s1_valid_q || s1_adv);
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_data;
    end
  end

  assign region    = iopr_pkg::bank_region(s1_req_q.address[iopr_pkg::ADDR_W-1 -: iopr_pkg::BANK_W]);
  assign is_write  = (s1_req_q.command == iopr_pkg::CMD_WRITE);
  assign is_colour = (region == iopr_pkg::REGION_COLOUR);

  assign colour_wr.en    = s1_adv && is_write && is_colour;
  assign colour_wr.index = s1_req_q.address[iopr_pkg::COLOUR_AW-1:0];
  assign colour_wr.nib   = s1_req_q.write_data[iopr_pkg::NIB_W-1:0];

  iopr_reg_file u_reg_file (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_vid_idx_i (req_data.address[iopr_pkg::VIDEO_AW-1:0]),
    .req_i        (s1_req_q),
    .wr_en_i      (s1_adv),
    .busy_o       (rf_busy),
    .status_o     (rf_status)
  );

  iopr_colour_store #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_colour_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_index_i (req_data.address[iopr_pkg::COLOUR_AW-1:0]),
    .wr_i       (colour_wr),
    .s1_index_i (s1_req_q.address[iopr_pkg::COLOUR_AW-1:0]),
    .busy_o     (colour_busy),
    .old_nib_o  (old_nib),
    .row_o      (row)
  );

  // Assemble the response
  assign colour_chg = is_write && is_colour && (colour_wr.nib != old_nib);

  always_comb begin
    out_d = '0;
    if (!is_write) begin
      out_d.read_data = is_colour ? {{(iopr_pkg::DATA_W - iopr_pkg::NIB_W){1'b0}}, old_nib}
                                  : rf_status.read_data;
    end else begin
      out_d.frame_changed  = rf_status.frame_changed;
      out_d.repaint_all    = rf_status.repaint_all;
      out_d.palette_update = rf_status.palette_update;
      out_d.border_changed = rf_status.border_changed;
    end
    if (colour_chg) begin
      out_d.colour_changed = 1'b1;
      out_d.colour_index   = colour_wr.index;
      out_d.colour_row     = row;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_req_q))
    else $error("request stage lost a stalled request");

  a_read_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !is_write |=> !out_q.frame_changed && !out_q.repaint_all &&
      !out_q.palette_update && !out_q.border_changed && !out_q.colour_changed)
    else $error("read response carries change flags");

  a_colour_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.colour_changed |-> out_q.colour_index == '0 && out_q.colour_row == '0)
    else $error("colour index or row set without a colour change");

endmodule

// ----- rtl/core/iopr_reg_file.sv -----
// Video, sound and both timer register files with power-on values and change flags.
// The video file is a memory loaded with its power-on values after reset.
// Depends on iopr_pkg for geometry, register offsets and the bank decode.
`timescale 1ns / 1ps

module iopr_reg_file (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [iopr_pkg::VIDEO_AW-1:0] rd_vid_idx_i,
  input  iopr_pkg::req_t                req_i,
  input  logic                          wr_en_i,
  output logic                          busy_o,
  output iopr_pkg::rf_status_t          status_o
);

  localparam int unsigned VAW = iopr_pkg::VIDEO_AW;

  logic [iopr_pkg::DATA_W-1:0] video_mem [iopr_pkg::VIDEO_DEPTH];
  logic [iopr_pkg::DATA_W-1:0] sound_q [iopr_pkg::SOUND_DEPTH];
  logic [iopr_pkg::DATA_W-1:0] tmr1_q  [iopr_pkg::TIMER_DEPTH];
  logic [iopr_pkg::DATA_W-1:0] tmr2_q  [iopr_pkg::TIMER_DEPTH];

  logic [iopr_pkg::DATA_W-1:0]     vid_rd_q;
  logic                            vid_byp_valid_q;
  logic [VAW-1:0]                  vid_byp_idx_q;
  logic [iopr_pkg::DATA_W-1:0]     vid_byp_data_q;
  logic                            vid_busy_q;
  logic [VAW-1:0]                  vid_clr_q;
  logic                            vid_wr;
  logic                            vid_we;
  logic [VAW-1:0]                  vid_waddr;
  logic [iopr_pkg::DATA_W-1:0]     vid_wdata;

  iopr_pkg::region_e               region;
  logic                            is_write;
  logic [iopr_pkg::VIDEO_AW-1:0]   vid_idx;
  logic [iopr_pkg::SOUND_AW-1:0]   snd_idx;
  logic [iopr_pkg::TIMER_AW-1:0]   tmr_idx;
  logic [iopr_pkg::DATA_W-1:0]     vid_prev;
  logic [iopr_pkg::DATA_W-1:0]     tmr2_prev;
  logic [iopr_pkg::DATA_W-1:0]     wdata;

  assign region    = iopr_pkg::bank_region(req_i.address[iopr_pkg::ADDR_W-1 -: iopr_pkg::BANK_W]);
  assign is_write  = (req_i.command == iopr_pkg::CMD_WRITE);
  assign vid_idx   = req_i.address[iopr_pkg::VIDEO_AW-1:0];
  assign snd_idx   = req_i.address[iopr_pkg::SOUND_AW-1:0];
  assign tmr_idx   = req_i.address[iopr_pkg::TIMER_AW-1:0];
  assign tmr2_prev = tmr2_q[tmr_idx];
  assign wdata     = req_i.write_data;

  // Video file: one write port shared by the power-on load and request writes
  assign busy_o    = vid_busy_q;
  assign vid_wr    = wr_en_i && is_write && (region == iopr_pkg::REGION_VIDEO);
  assign vid_we    = vid_busy_q | vid_wr;
  assign vid_waddr = vid_busy_q ? vid_clr_q : vid_idx;
  assign vid_wdata = vid_busy_q ? iopr_pkg::video_reset_value(vid_clr_q) : wdata;

  // Registered read on request acceptance
  always_ff @(posedge clk_i) begin
    if (vid_we) begin
      video_mem[vid_waddr] <= vid_wdata;
    end
    if (rd_en_i) begin
      vid_rd_q <= video_mem[rd_vid_idx_i];
    end
  end

  // Capture a video write landing on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_byp_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      vid_byp_valid_q <= vid_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      vid_byp_idx_q  <= vid_idx;
      vid_byp_data_q <= wdata;
    end
  end

  assign vid_prev = (vid_byp_valid_q && vid_byp_idx_q == vid_idx) ? vid_byp_data_q : vid_rd_q;

  // Load power-on values into the video file after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vid_busy_q <= 1'b1;
      vid_clr_q  <= '0;
    end else if (vid_busy_q) begin
      vid_clr_q <= vid_clr_q + VAW'(1);
      if (vid_clr_q == VAW'(iopr_pkg::VIDEO_DEPTH - 1)) begin
        vid_busy_q <= 1'b0;
      end
    end
  end

  // Select the read byte and raise flags on real value changes
  always_comb begin
    status_o = '0;
    case (region)
      iopr_pkg::REGION_VIDEO:     status_o.read_data = vid_prev;
      iopr_pkg::REGION_SOUND:     status_o.read_data = sound_q[snd_idx];
      iopr_pkg::REGION_TIMER_ONE: status_o.read_data = tmr1_q[tmr_idx];
      iopr_pkg::REGION_TIMER_TWO: status_o.read_data = tmr2_prev;
      default:                    status_o.read_data = 8'hFF;
    endcase

    if (is_write && region == iopr_pkg::REGION_VIDEO && vid_prev != wdata) begin
      case (vid_idx)
        iopr_pkg::VID_CTRL_V, iopr_pkg::VID_CTRL_H, iopr_pkg::VID_MEM_PTR: begin
          status_o.frame_changed = 1'b1;
          status_o.repaint_all   = 1'b1;
        end
        iopr_pkg::VID_BACKGROUND: begin
          status_o.palette_update = 1'b1;
          status_o.repaint_all    = 1'b1;
        end
        iopr_pkg::VID_BORDER: begin
          status_o.palette_update = 1'b1;
          status_o.border_changed = 1'b1;
        end
        default: ;
      endcase
    end

    // Bank bits of timer-two port A select the video frame
    if (is_write && region == iopr_pkg::REGION_TIMER_TWO && tmr_idx == iopr_pkg::TMR_PORT_A &&
        (tmr2_prev[1:0] ^ wdata[1:0]) != 2'b00) begin
      status_o.frame_changed = 1'b1;
      status_o.repaint_all   = 1'b1;
    end
  end

  // Store written bytes; video, unmapped and colour banks leave these files alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iopr_pkg::SOUND_DEPTH; i++) begin
        sound_q[i] <= '0;
      end
      for (int i = 0; i < iopr_pkg::TIMER_DEPTH; i++) begin
        tmr1_q[i] <= iopr_pkg::timer_one_reset_value(iopr_pkg::TIMER_AW'(i));
        tmr2_q[i] <= iopr_pkg::timer_two_reset_value(iopr_pkg::TIMER_AW'(i));
      end
    end else if (wr_en_i && is_write) begin
      case (region)
        iopr_pkg::REGION_SOUND:     sound_q[snd_idx] <= wdata;
        iopr_pkg::REGION_TIMER_ONE: tmr1_q[tmr_idx]  <= wdata;
        iopr_pkg::REGION_TIMER_TWO: tmr2_q[tmr_idx]  <= wdata;
        default: ;
      endcase
    end
  end

  a_vid_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vid_busy_q |=> !vid_busy_q)
    else $error("video file load restarted outside reset");

  a_vid_load_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vid_busy_q && vid_clr_q == VAW'(iopr_pkg::VIDEO_DEPTH - 1) |=> !vid_busy_q)
    else $error("video file load did not end after the last entry");

  a_no_access_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vid_busy_q |-> !rd_en_i && !wr_en_i)
    else $error("video file accessed during power-on load");

endmodule

// ----- rtl/core/iopr_colour_store.sv -----
// Colour nibble memory with clearing sweep after reset, write bypass and row computation.
// Depends on iopr_pkg for geometry and the write port struct.
`timescale 1ns / 1ps

module iopr_colour_store #(
  parameter int unsigned SCREEN_COLUMNS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [iopr_pkg::COLOUR_AW-1:0]   rd_index_i,
  input  iopr_pkg::colour_wr_t             wr_i,
  input  logic [iopr_pkg::COLOUR_AW-1:0]   s1_index_i,
  output logic                             busy_o,
  output logic [iopr_pkg::NIB_W-1:0]       old_nib_o,
  output logic [iopr_pkg::ROW_W-1:0]       row_o
);

  localparam int unsigned AW = iopr_pkg::COLOUR_AW;
  // Exact reciprocal for any index below 2**AW and columns up to 2**AW
  localparam int unsigned ROW_SHIFT = 2 * AW;
  localparam int unsigned RECIP_W   = ROW_SHIFT + 1;
  localparam int unsigned PROD_W    = AW + RECIP_W;
  localparam int unsigned COL_RECIP =
    ((1 << ROW_SHIFT) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;

  logic [iopr_pkg::NIB_W-1:0] mem [iopr_pkg::COLOUR_DEPTH];
  logic [iopr_pkg::NIB_W-1:0] rd_q;
  logic                       byp_valid_q;
  logic [AW-1:0]              byp_index_q;
  logic [iopr_pkg::NIB_W-1:0] byp_nib_q;
  logic                       busy_q;
  logic [AW-1:0]              clr_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [iopr_pkg::NIB_W-1:0] mem_wdata;
  logic [PROD_W-1:0]          prod;

  assign busy_o    = busy_q;
  assign mem_we    = busy_q | wr_i.en;
  assign mem_waddr = busy_q ? clr_q : wr_i.index;
  assign mem_wdata = busy_q ? '0 : wr_i.nib;

  // Single write port, registered read on request acceptance
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_index_i];
    end
  end

  // Capture a write landing on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_valid_q <= wr_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_index_q <= wr_i.index;
      byp_nib_q   <= wr_i.nib;
    end
  end

  assign old_nib_o = (byp_valid_q && byp_index_q == s1_index_i) ? byp_nib_q : rd_q;

  // Sweep zeros through the whole store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(iopr_pkg::COLOUR_DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Row = index / columns by reciprocal multiply, then masked to the row width
  assign prod  = {{RECIP_W{1'b0}}, s1_index_i} * PROD_W'(COL_RECIP);
  assign row_o = prod[ROW_SHIFT +: iopr_pkg::ROW_W];

  a_sweep_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !busy_q)
    else $error("colour store sweep restarted outside reset");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && clr_q == AW'(iopr_pkg::COLOUR_DEPTH - 1) |=> !busy_q)
    else $error("colour store sweep did not end after the last nibble");

  a_no_access_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rd_en_i && !wr_i.en)
    else $error("colour store accessed during clearing sweep");

endmodule
